// ===== hw/rtl/spf_pkg.sv =====
// Package for the segmented packet framer: payload types, framing constants,
// mode codes and the CRC-16-CCITT byte update. No dependencies.
`default_nettype none

package spf_pkg;

    // Default depth of the payload store
    localparam int BUF_DEPTH_DEF = 64;

    // Framing constants
    localparam logic [6:0]  HDR_LEN      = 7'd5;
    localparam logic [6:0]  SIZE_MIN     = 7'd8;
    localparam logic [6:0]  SIZE_RST     = 7'd64;
    localparam logic [6:0]  POS_MAX      = 7'd127;
    localparam logic [7:0]  COUNTER_RST  = 8'd1;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [7:0]  FLAG_CONT    = 8'h02;
    localparam logic [7:0]  FLAG_LAST    = 8'h01;

    // Header byte positions
    localparam logic [6:0] POS_TYPE   = 7'd0;
    localparam logic [6:0] POS_NUMBER = 7'd1;
    localparam logic [6:0] POS_TRANS  = 7'd2;
    localparam logic [6:0] POS_LEN_HI = 7'd3;
    localparam logic [6:0] POS_LEN_LO = 7'd4;

    // Input mode codes
    localparam logic [1:0] MODE_OPEN  = 2'd0;
    localparam logic [1:0] MODE_DATA  = 2'd1;
    localparam logic [1:0] MODE_CLOSE = 2'd2;

    // Configuration register word index
    localparam logic REG_PKT_SIZE = 1'b0;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] packet_type;
        logic [7:0] txn_tag;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
    } out_item_t;

    // Datapath status seen by the controller
    typedef struct packed {
        logic full;
        logic last_idx;
        logic out_free;
    } status_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic take;
        logic open;
        logic store;
        logic start_emit;
        logic last;
        logic send_byte;
        logic send_crc_hi;
        logic send_crc_lo;
        logic finish_flush;
    } cmd_t;

    // CRC-16-CCITT, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/segmented_packet_framer_crc16_top.sv =====
// Segmented packet framer with CRC-16-CCITT. Open, plain data and unused-mode
// items are taken in the idle state and transfer no bytes. A close, or a data byte
// into a full packet, transfers write_position + 2 bytes at one per cycle while the
// output accepts them, payload bytes from the store's registered read; the input
// is ready again the cycle after the CRC low byte loads.
// Reset (rst_n, async, low) sets position 5, packet counter 1, size 64; store kept.
`default_nettype none

module segmented_packet_framer_crc16_top #(
    parameter int BUF_DEPTH = spf_pkg::BUF_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire spf_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output spf_pkg::out_item_t      out_data
);

    logic [6:0]       buf_size_reg;
    logic [6:0]       buf_size_next;
    logic             reg_hit;
    spf_pkg::status_t status;
    spf_pkg::cmd_t    cmd;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == spf_pkg::REG_PKT_SIZE);

    // Register write on the access cycle
    always_comb
    begin
        buf_size_next = buf_size_reg;
        if (psel && penable && pwrite && reg_hit)
            buf_size_next = pwdata[6:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            buf_size_reg <= spf_pkg::SIZE_RST;
        else
            buf_size_reg <= buf_size_next;
    end

    // Register read, with the unused byte offset ignored
    assign prdata = reg_hit ? {25'd0, buf_size_reg} : 32'd0;

    spf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (in_data.mode),
        .status   (status),
        .cmd      (cmd)
    );

    spf_dp #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .buf_size  (buf_size_reg),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/spf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read port, hold data when not reading
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/spf_ctrl.sv =====
// Controller of the packet framer: decodes accepted items and sequences a
// packet transfer byte by byte. Depends on spf_pkg.
`default_nettype none

module spf_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [1:0]      mode,
    input  wire spf_pkg::status_t status,
    output spf_pkg::cmd_t        cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEND   = 4'b0010,
        ST_CRC_HI = 4'b0100,
        ST_CRC_LO = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   flush_reg, flush_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
        end
    end

    // Decode items and step through a packet
    always_comb
    begin
        state_next = state_reg;
        flush_next = flush_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    unique case (mode)
                        spf_pkg::MODE_OPEN:
                            cmd.open = 1'b1;
                        spf_pkg::MODE_DATA:
                        begin
                            if (status.full)
                            begin
                                cmd.start_emit = 1'b1;
                                flush_next     = 1'b1;
                                state_next     = ST_SEND;
                            end
                            else
                                cmd.store = 1'b1;
                        end
                        spf_pkg::MODE_CLOSE:
                        begin
                            cmd.start_emit = 1'b1;
                            cmd.last       = 1'b1;
                            flush_next     = 1'b0;
                            state_next     = ST_SEND;
                        end
                        default:
                            ;
                    endcase
                end
            end
            ST_SEND:
            begin
                if (status.out_free)
                begin
                    cmd.send_byte = 1'b1;
                    if (status.last_idx)
                        state_next = ST_CRC_HI;
                end
            end
            ST_CRC_HI:
            begin
                if (status.out_free)
                begin
                    cmd.send_crc_hi = 1'b1;
                    state_next      = ST_CRC_LO;
                end
            end
            ST_CRC_LO:
            begin
                if (status.out_free)
                begin
                    cmd.send_crc_lo  = 1'b1;
                    cmd.finish_flush = flush_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/spf_dp.sv =====
// Datapath of the packet framer: framing state, payload store, header and
// CRC generation, output register. Depends on spf_pkg and spf_ram.
`default_nettype none

module spf_dp #(
    parameter int BUF_DEPTH = spf_pkg::BUF_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire spf_pkg::in_item_t in_data,
    input  wire logic [6:0]        buf_size,
    input  wire spf_pkg::cmd_t     cmd,
    output spf_pkg::status_t       status,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output spf_pkg::out_item_t     out_data
);

    localparam int AddrW = $clog2(BUF_DEPTH);
    localparam int SizeTop = (BUF_DEPTH < 127) ? BUF_DEPTH : 127;
    localparam logic [6:0] SizeTopV = 7'(SizeTop);

    logic [6:0]  wp_reg, wp_next;
    logic [7:0]  counter_reg, counter_next;
    logic [3:0]  type_reg, type_next;
    logic        cont_reg, cont_next;
    logic [7:0]  trans_reg, trans_next;
    logic        last_reg;
    logic [7:0]  pend_reg;
    logic [6:0]  idx_reg;
    logic [15:0] crc_reg;
    logic        out_valid_reg;
    spf_pkg::out_item_t out_reg;

    logic [6:0]       eff_size;
    logic [7:0]       cur_byte;
    logic [7:0]       ram_q;
    logic             ram_we;
    logic [AddrW-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic [AddrW-1:0] ram_raddr;
    logic [6:0]       idx_inc;
    logic [6:0]       len_lo;
    logic             load;

    // Clamp the configured packet size
    always_comb
    begin
        priority if (buf_size < spf_pkg::SIZE_MIN)
            eff_size = spf_pkg::SIZE_MIN;
        else if (buf_size > SizeTopV)
            eff_size = SizeTopV;
        else
            eff_size = buf_size;
    end

    assign idx_inc = idx_reg + 7'd1;
    assign len_lo  = wp_reg - 7'd3;

    assign status.full     = (wp_reg >= (eff_size - 7'd2));
    assign status.last_idx = (idx_reg == (wp_reg - 7'd1));
    assign status.out_free = !out_valid_reg || out_ready;

    // Select the header or payload byte at the current position
    always_comb
    begin
        unique case (idx_reg)
            spf_pkg::POS_TYPE:
                cur_byte = {type_reg, 4'h0}
                         | (cont_reg ? spf_pkg::FLAG_CONT : 8'h00)
                         | (last_reg ? spf_pkg::FLAG_LAST : 8'h00);
            spf_pkg::POS_NUMBER:
                cur_byte = counter_reg - 8'd1;
            spf_pkg::POS_TRANS:
                cur_byte = trans_reg;
            spf_pkg::POS_LEN_HI:
                cur_byte = 8'h00;
            spf_pkg::POS_LEN_LO:
                cur_byte = {1'b0, len_lo};
            default:
                cur_byte = ram_q;
        endcase
    end

    // Payload store write: plain store at the write position, or the held
    // byte at the first payload slot after a flush
    always_comb
    begin
        ram_we    = cmd.store || cmd.finish_flush;
        ram_waddr = cmd.finish_flush ? AddrW'(spf_pkg::HDR_LEN) : AddrW'(wp_reg);
        ram_wdata = cmd.finish_flush ? pend_reg : in_data.data_byte;
        ram_raddr = AddrW'(idx_inc);
    end

    spf_ram #(
        .WIDTH(8),
        .DEPTH(BUF_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.send_byte),
        .rd_addr (ram_raddr),
        .rd_data (ram_q)
    );

    // Next framing state
    always_comb
    begin
        wp_next      = wp_reg;
        counter_next = counter_reg;
        type_next    = type_reg;
        cont_next    = cont_reg;
        trans_next   = trans_reg;
        if (cmd.open)
        begin
            type_next    = in_data.packet_type;
            trans_next   = in_data.txn_tag;
            cont_next    = 1'b0;
            counter_next = counter_reg + 8'd1;
            wp_next      = spf_pkg::HDR_LEN;
        end
        if (cmd.store)
            wp_next = wp_reg + 7'd1;
        if (cmd.finish_flush)
        begin
            cont_next    = 1'b1;
            counter_next = counter_reg + 8'd1;
            wp_next      = spf_pkg::HDR_LEN + 7'd1;
        end
    end

    // Hold framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= spf_pkg::HDR_LEN;
            counter_reg <= spf_pkg::COUNTER_RST;
            type_reg    <= 4'h0;
            cont_reg    <= 1'b0;
            trans_reg   <= 8'h00;
        end
        else
        begin
            wp_reg      <= wp_next;
            counter_reg <= counter_next;
            type_reg    <= type_next;
            cont_reg    <= cont_next;
            trans_reg   <= trans_next;
        end
    end

    // Latch the item byte, emit flags, position and running CRC
    always_ff @(posedge clk)
    begin
        if (cmd.take)
            pend_reg <= in_data.data_byte;
        if (cmd.start_emit)
        begin
            last_reg <= cmd.last;
            idx_reg  <= 7'd0;
            crc_reg  <= spf_pkg::CRC_INIT;
        end
        else if (cmd.send_byte)
        begin
            idx_reg <= idx_inc;
            crc_reg <= spf_pkg::crc_byte(crc_reg, cur_byte);
        end
    end

    assign load = cmd.send_byte || cmd.send_crc_hi || cmd.send_crc_lo;

    // Output register: load a byte, drop valid once the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.send_byte)
        begin
            out_reg.out_byte   <= cur_byte;
            out_reg.packet_end <= 1'b0;
        end
        else if (cmd.send_crc_hi)
        begin
            out_reg.out_byte   <= crc_reg[15:8];
            out_reg.packet_end <= 1'b0;
        end
        else if (cmd.send_crc_lo)
        begin
            out_reg.out_byte   <= crc_reg[7:0];
            out_reg.packet_end <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    // A new byte never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load && out_valid_reg |-> out_ready)
        else $error("output byte overwritten before transfer");

    // The write position stays inside the header-to-store range
    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg >= spf_pkg::HDR_LEN && int'(wp_reg) < BUF_DEPTH)
        else $error("write position out of range");

    // The CRC low byte closes the packet
    a_crc_lo_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.send_crc_lo |=> out_valid_reg && out_reg.packet_end)
        else $error("packet end missing after CRC low byte");

    // Only a position below the write position is sent
    a_read_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.send_byte |-> idx_reg < wp_reg)
        else $error("packet byte beyond write position");
`endif

endmodule

`default_nettype wire
